[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle, checked on the rising edge, idle in reset.
`define BQF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("biquad check failed");

// Antecedent in one cycle, consequent in the next cycle.
`define BQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("biquad check failed");

`endif

[hdl/biquad_pkg.sv]
// Shared constants, types and rounding function of the biquad filter.
package biquad_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int QUOT_BITS      = ACC_BITS - COEF_FRAC_BITS;

  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int REG_IDX_BITS = 3;
  localparam int NUM_REGS     = 6;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_GAIN = 3'd0;
  localparam reg_idx_t REG_B0   = 3'd1;
  localparam reg_idx_t REG_B1   = 3'd2;
  localparam reg_idx_t REG_B2   = 3'd3;
  localparam reg_idx_t REG_A1   = 3'd4;
  localparam reg_idx_t REG_A2   = 3'd5;

  localparam logic signed [COEF_BITS-1:0] COEF_UNITY =
    COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  // multiplier operand select
  typedef logic [2:0] msel_t;
  localparam msel_t MSEL_GAIN = 3'd0;
  localparam msel_t MSEL_B0   = 3'd1;
  localparam msel_t MSEL_B1   = 3'd2;
  localparam msel_t MSEL_B2   = 3'd3;
  localparam msel_t MSEL_A1   = 3'd4;
  localparam msel_t MSEL_A2   = 3'd5;

  // accumulator operation
  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_ADD  = 2'd2;
  localparam acc_op_t ACC_SUB  = 2'd3;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] gain;
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic    mul_en;
    msel_t   mul_sel;
    logic    take_x0;
    acc_op_t acc_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
  } sat_t;

  localparam logic [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [QUOT_BITS-1:0] QUOT_MAX =
    QUOT_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [QUOT_BITS-1:0] QUOT_MIN = ~QUOT_MAX;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Round half up out of the fraction bits, then clamp to the sample range.
  function automatic sat_t round_sat(input logic signed [ACC_BITS-1:0] v);
    logic [ACC_BITS-1:0]          r;
    logic signed [QUOT_BITS-1:0]  q;
    sat_t                         res;
    r = v + ROUND_HALF;
    q = r[ACC_BITS-1:COEF_FRAC_BITS];
    if (q > QUOT_MAX) begin
      res.sample = SAMPLE_MAX;
      res.clip   = 1'b1;
    end else if (q < QUOT_MIN) begin
      res.sample = SAMPLE_MIN;
      res.clip   = 1'b1;
    end else begin
      res.sample = q[SAMPLE_BITS-1:0];
      res.clip   = 1'b0;
    end
    return res;
  endfunction

endpackage

[hdl/biquad_regs.sv]
// Coefficient and gain register file behind the APB-style port.
module biquad_regs
  import biquad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output coef_t                coef
);

  reg_idx_t                    idx;
  logic                        wr;
  logic signed [COEF_BITS-1:0] rd;
  logic signed [COEF_BITS-1:0] wdata;

  assign idx   = paddr[ADDR_BITS-1:2];
  assign wr    = psel & penable & pwrite;
  assign wdata = pwdata[COEF_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.gain <= COEF_UNITY;
      coef.b0   <= COEF_UNITY;
      coef.b1   <= '0;
      coef.b2   <= '0;
      coef.a1   <= '0;
      coef.a2   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN: coef.gain <= wdata;
        REG_B0:   coef.b0   <= wdata;
        REG_B1:   coef.b1   <= wdata;
        REG_B2:   coef.b2   <= wdata;
        REG_A1:   coef.a1   <= wdata;
        REG_A2:   coef.a2   <= wdata;
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN: rd = coef.gain;
      REG_B0:   rd = coef.b0;
      REG_B1:   rd = coef.b1;
      REG_B2:   rd = coef.b2;
      REG_A1:   rd = coef.a1;
      REG_A2:   rd = coef.a2;
      default:  rd = '0;
    endcase
  end

  assign prdata = {{(DATA_BITS-COEF_BITS){1'b0}}, rd};

endmodule

[hdl/biquad_ctrl.sv]
// Sequencer that steps the shared multiply-accumulate through one item.
module biquad_ctrl
  import biquad_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [2:0] STEP_FINAL = 3'd4;

  logic [1:0] state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.mul_sel = MSEL_GAIN;
        cmd.mul_en  = stat.in_valid;
        if (stat.in_valid) begin
          state_next = ST_MAC;
          step_next  = '0;
        end
      end
      ST_MAC: begin
        // products go in as b1x1, b2x2, a1y1, a2y2, b0x0; acc trails them through prod
        cmd.mul_en = 1'b1;
        step_next  = step + 3'd1;
        unique case (step)
          3'd0: begin
            cmd.mul_sel = MSEL_B1;
            cmd.take_x0 = 1'b1;
            cmd.acc_op  = ACC_HOLD;
          end
          3'd1: begin
            cmd.mul_sel = MSEL_B2;
            cmd.acc_op  = ACC_LOAD;
          end
          3'd2: begin
            cmd.mul_sel = MSEL_A1;
            cmd.acc_op  = ACC_ADD;
          end
          3'd3: begin
            cmd.mul_sel = MSEL_A2;
            cmd.acc_op  = ACC_SUB;
          end
          default: begin
            cmd.mul_sel = MSEL_B0;
            cmd.acc_op  = ACC_SUB;
          end
        endcase
        if (step == STEP_FINAL) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

endmodule

[hdl/biquad_dp.sv]
// Datapath: shared multiplier, accumulator, tap registers and output register.
module biquad_dp
  import biquad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  coef_t                         coef,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_free,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_clip
);

  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [SAMPLE_BITS-1:0] x0, x1, x2, y1, y2;
  logic                          clip_in;
  sat_t                          gain_res;
  sat_t                          sum_res;

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_GAIN: begin mul_a = coef.gain; mul_b = sample_in; end
      MSEL_B0:   begin mul_a = coef.b0;   mul_b = x0;        end
      MSEL_B1:   begin mul_a = coef.b1;   mul_b = x1;        end
      MSEL_B2:   begin mul_a = coef.b2;   mul_b = x2;        end
      MSEL_A1:   begin mul_a = coef.a1;   mul_b = y1;        end
      MSEL_A2:   begin mul_a = coef.a2;   mul_b = y2;        end
      default:   begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign prod_ext = ACC_BITS'(prod);

  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      ACC_HOLD: acc <= acc;
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      ACC_SUB:  acc <= acc - prod_ext;
    endcase
  end

  assign gain_res = round_sat(prod_ext);
  assign sum_res  = round_sat(acc);

  always_ff @(posedge clk) begin
    if (cmd.take_x0) begin
      x0      <= gain_res.sample;
      clip_in <= gain_res.clip;
    end
  end

  // taps are filter state and start from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (cmd.out_load) begin
      x2 <= x1;
      x1 <= x0;
      y2 <= y1;
      y1 <= sum_res.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample <= sum_res.sample;
      out_clip   <= clip_in | sum_res.clip;
    end
  end

  assign out_free = ~out_valid | out_ready;

endmodule

[hdl/biquad_iir_filter.sv]
// Items pass one at a time through the single shared 24x16 multiplier:
//   gain product on accept, then five tap products, one last accumulate,
//   then a round into the output register, raising m_tvalid once it is free.
// s_tready is high only while the sequencer idles; a held output stalls it.
// Reset (rst, synchronous, active high): taps cleared, gain and b0 at 1.0,
//   other coefficients zero, output register empty.
module biquad_iir_filter
  import biquad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // slave stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample_in
  // master stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_BITS-1:0] m_tdata,   // [15:0] sample_out
  output logic                   m_tuser,   // [0] clipped
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready
);

  coef_t                         coef;
  cmd_t                          cmd;
  stat_t                         stat;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  // zero wait states on the config port
  assign pready = 1'b1;

  biquad_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  // sequencer sees only the input valid and whether the output slot frees up
  assign stat.in_valid = s_tvalid;
  assign stat.out_free = out_free;

  biquad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  // gain product is taken straight off s_tdata in the accepting cycle, so no
  // input holding register is needed
  biquad_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .sample_in  (signed'(s_tdata)),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_free   (out_free),
    .out_sample (out_sample),
    .out_clip   (m_tuser)
  );

  assign m_tdata = out_sample;

endmodule

[hdl/biquad_checker.sv]
// Port-level checks for the biquad filter, bound to the top level.
`include "assert_macros.svh"

module biquad_checker
  import biquad_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [SAMPLE_BITS-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [ADDR_BITS-1:0]   paddr,
  input logic [DATA_BITS-1:0]   pwdata,
  input logic [DATA_BITS-1:0]   prdata,
  input logic                   pready
);

  logic                 cfg_wr;
  logic                 cfg_mapped;
  logic                 cfg_hit;
  logic                 s_fire;
  logic                 out_stall;
  logic [SAMPLE_BITS:0] out_word;
  logic [COEF_BITS-1:0] rd_val;
  logic [COEF_BITS-1:0] wr_val;

  assign cfg_wr     = psel & penable & pwrite & pready;
  assign cfg_mapped = (paddr[ADDR_BITS-1:2] < REG_IDX_BITS'(NUM_REGS));
  assign cfg_hit    = cfg_wr & cfg_mapped;
  assign s_fire     = s_tvalid & s_tready;
  assign out_stall  = m_tvalid & ~m_tready;
  assign out_word   = {m_tuser, m_tdata};
  assign rd_val     = prdata[COEF_BITS-1:0];
  assign wr_val     = pwdata[COEF_BITS-1:0];

  // a stalled result holds still
  `BQF_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(out_word))

  // one item at a time: input stays closed through the whole sequence
  `BQF_ASSERT_NEXT(a_busy_window, clk, rst, s_fire, !s_tready [*7])

  // a new result appears only out of a busy cycle
  `BQF_ASSERT(a_out_from_busy, clk, rst, !$rose(m_tvalid) || !$past(s_tready))

  // a mapped register reads back what was just written to it, if the address holds
  `BQF_ASSERT_NEXT(a_readback, clk, rst, cfg_hit, !$stable(paddr) || (rd_val == $past(wr_val)))

endmodule

bind biquad_iir_filter biquad_checker u_chk (.*);
